// ===== sv/lsp_pkg.sv =====
// Shared types and constants of the line stroke pixel shader.
// No dependencies; taken in by the interfaces and the top level.
package lsp_pkg;

  localparam int CoordW = 10;
  localparam int PixW   = 16;

  typedef enum logic [2:0] {
    REG_LINE_START     = 3'd0,
    REG_LINE_END       = 3'd1,
    REG_STROKE_WIDTH   = 3'd2,
    REG_PAINT          = 3'd3,
    REG_CLIP_BOX       = 3'd4,
    REG_CLIP_CENTRE    = 3'd5,
    REG_CLIP_RADIUS_SQ = 3'd6,
    REG_CLIP_ENABLES   = 3'd7
  } lsp_reg_e;

  typedef struct packed {
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [PixW-1:0]   dst;
    logic              ok;
  } lsp_meta_t;

endpackage

// ===== sv/lsp_in_if.sv =====
// Pixel request channel: coordinates and current framebuffer value.
// Depends on lsp_pkg for field widths.
interface lsp_in_if import lsp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CoordW-1:0] pixel_x;
  logic [CoordW-1:0] pixel_y;
  logic [PixW-1:0]   dest_pixel;

  modport source (output valid, output pixel_x, output pixel_y, output dest_pixel,
                  input ready);
  modport sink (input valid, input pixel_x, input pixel_y, input dest_pixel,
                output ready);
endinterface

// ===== sv/lsp_out_if.sv =====
// Shaded pixel result channel.
// Depends on lsp_pkg for field widths.
interface lsp_out_if import lsp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CoordW-1:0] out_x;
  logic [CoordW-1:0] out_y;
  logic [PixW-1:0]   new_pixel;
  logic              covered;

  modport source (output valid, output out_x, output out_y, output new_pixel,
                  output covered, input ready);
  modport sink (input valid, input out_x, input out_y, input new_pixel,
                input covered, output ready);
endinterface

// ===== sv/line_stroke_pixel_shader_top.sv =====
// Line stroke pixel shader: capsule coverage test with box and circle clipping, and RGB565 alpha blend.
// One pixel per clock sustained while the output channel is ready.
// Each of the 7 stages stalls on its own, so bubbles close up under backpressure.
// Reset empties the pipeline and clears every configuration register to zero.
// Depends on lsp_pkg, lsp_in_if and lsp_out_if.
module line_stroke_pixel_shader_top
  import lsp_pkg::*;
#(
  parameter int CANVAS_WIDTH    = 512,
  parameter int CANVAS_HEIGHT   = 512,
  parameter int COORD_FRAC_BITS = 4
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [5:0]   paddr,
  input  logic [63:0]  pwdata,
  output logic [63:0]  prdata,
  output logic         pready,
  lsp_in_if.sink       in_if,
  lsp_out_if.source    out_if
);

  localparam int F    = COORD_FRAC_BITS;
  localparam int WW   = ((12 + F) > 17 ? (12 + F) : 17) + 1;
  localparam int DW   = 18;
  localparam int PRW  = WW + DW;
  localparam int CRW  = PRW + 1;
  localparam int H    = (CRW + 1) / 2;
  localparam int HI   = CRW - H;
  localparam int SQW  = 2 * WW;
  localparam int LW   = 2 * DW;
  localparam int LH   = LW / 2;
  localparam int SWW  = 24;
  localparam int RLW  = SWW + LW;
  localparam int CQW  = 2 * CRW;
  localparam int SH   = 2 * F + 2;
  localparam int DTW  = (SQW + 10) > (SWW + SH) ? (SQW + 10) : (SWW + SH);
  localparam int CTW  = (SQW + 8) > (32 + SH) ? (SQW + 8) : (32 + SH);
  localparam int CMPW = (CQW + 10) > (RLW + SH) ? (CQW + 10) : (RLW + SH);
  localparam int MXW  = (PRW + 1) > (LW + 1) ? (PRW + 1) : (LW + 1);
  localparam int SHORT_LIM = (1 << SH) / 10000;

  function automatic logic signed [WW-1:0] coord2(input logic [15:0] v);
    return WW'($signed({v, 1'b0}));
  endfunction

  function automatic logic signed [WW-1:0] centre2(input logic [9:0] p);
    return $signed(WW'({p, 1'b1}) << F);
  endfunction

  // configuration registers
  logic [31:0] line_start_q, line_end_q, paint_q, clip_centre_q, clip_radius_sq_q;
  logic [11:0] stroke_width_q;
  logic [39:0] clip_box_q;
  logic [1:0]  clip_enables_q;
  logic        cfg_we;
  lsp_reg_e    cfg_idx;

  assign cfg_we  = psel & penable & pwrite;
  assign cfg_idx = lsp_reg_e'(paddr[5:3]);
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_start_q     <= '0;
      line_end_q       <= '0;
      stroke_width_q   <= '0;
      paint_q          <= '0;
      clip_box_q       <= '0;
      clip_centre_q    <= '0;
      clip_radius_sq_q <= '0;
      clip_enables_q   <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_LINE_START:     line_start_q     <= pwdata[31:0];
        REG_LINE_END:       line_end_q       <= pwdata[31:0];
        REG_STROKE_WIDTH:   stroke_width_q   <= pwdata[11:0];
        REG_PAINT:          paint_q          <= pwdata[31:0];
        REG_CLIP_BOX:       clip_box_q       <= pwdata[39:0];
        REG_CLIP_CENTRE:    clip_centre_q    <= pwdata[31:0];
        REG_CLIP_RADIUS_SQ: clip_radius_sq_q <= pwdata[31:0];
        REG_CLIP_ENABLES:   clip_enables_q   <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_LINE_START:     prdata = 64'(line_start_q);
      REG_LINE_END:       prdata = 64'(line_end_q);
      REG_STROKE_WIDTH:   prdata = 64'(stroke_width_q);
      REG_PAINT:          prdata = 64'(paint_q);
      REG_CLIP_BOX:       prdata = 64'(clip_box_q);
      REG_CLIP_CENTRE:    prdata = 64'(clip_centre_q);
      REG_CLIP_RADIUS_SQ: prdata = 64'(clip_radius_sq_q);
      REG_CLIP_ENABLES:   prdata = 64'(clip_enables_q);
      default:            prdata = '0;
    endcase
  end

  // stage control
  logic [7:1] v_q, v_d, en;

  always_comb begin
    en[7] = ~v_q[7] | out_if.ready;
    for (int k = 6; k >= 1; k--) begin
      en[k] = ~v_q[k] | en[k+1];
    end
    v_d[1] = en[1] ? in_if.valid : v_q[1];
    for (int k = 2; k <= 7; k++) begin
      v_d[k] = en[k] ? v_q[k-1] : v_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign in_if.ready = en[1];

  // stage 1: differences, canvas and rectangle tests
  logic signed [WW-1:0] px, py, ax, ay, bx, by;
  logic signed [WW-1:0] wx1_d, wy1_d, ex1_d, ey1_d, cx1_d, cy1_d;
  logic signed [WW-1:0] wx1_q, wy1_q, ex1_q, ey1_q, cx1_q, cy1_q;
  logic signed [DW-1:0] dx1_d, dy1_d, dx1_q, dy1_q;
  lsp_meta_t            m1_d, m1_q;
  logic                 box_ok, canvas_ok;

  assign px = centre2(in_if.pixel_x);
  assign py = centre2(in_if.pixel_y);
  assign ax = coord2(line_start_q[15:0]);
  assign ay = coord2(line_start_q[31:16]);
  assign bx = coord2(line_end_q[15:0]);
  assign by = coord2(line_end_q[31:16]);

  always_comb begin
    wx1_d = px - ax;
    wy1_d = py - ay;
    ex1_d = px - bx;
    ey1_d = py - by;
    cx1_d = px - coord2(clip_centre_q[15:0]);
    cy1_d = py - coord2(clip_centre_q[31:16]);
    dx1_d = DW'(bx - ax);
    dy1_d = DW'(by - ay);
    canvas_ok = (11'(in_if.pixel_x) < 11'(CANVAS_WIDTH)) &&
                (11'(in_if.pixel_y) < 11'(CANVAS_HEIGHT));
    box_ok = ~clip_enables_q[0] ||
             ((in_if.pixel_x >= clip_box_q[9:0])   && (in_if.pixel_x <= clip_box_q[29:20]) &&
              (in_if.pixel_y >= clip_box_q[19:10]) && (in_if.pixel_y <= clip_box_q[39:30]));
    m1_d.x   = in_if.pixel_x;
    m1_d.y   = in_if.pixel_y;
    m1_d.dst = in_if.dest_pixel;
    m1_d.ok  = (stroke_width_q > 12'd8) && (paint_q[31:24] != 8'd0) && canvas_ok && box_ok;
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      wx1_q <= wx1_d;
      wy1_q <= wy1_d;
      ex1_q <= ex1_d;
      ey1_q <= ey1_d;
      cx1_q <= cx1_d;
      cy1_q <= cy1_d;
      dx1_q <= dx1_d;
      dy1_q <= dy1_d;
      m1_q  <= m1_d;
    end
  end

  // stage 2: products
  logic signed [PRW-1:0] pdx2_q, pdy2_q, pcx2_q, pcy2_q;
  logic signed [SQW-1:0] swx2_q, swy2_q, sex2_q, sey2_q, scx2_q, scy2_q;
  logic signed [LW-1:0]  sdx2_q, sdy2_q;
  logic [SWW-1:0]        sw2_2_q;
  logic [13:0]           bsr2_q, bsg2_q, bsb2_q, bdr2_q, bdg2_q, bdb2_q;
  lsp_meta_t             m2_q;
  logic [7:0]            alpha, alpha_inv;

  assign alpha     = paint_q[31:24];
  assign alpha_inv = 8'(8'd255 - alpha);

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      pdx2_q  <= PRW'(wx1_q) * PRW'(dx1_q);
      pdy2_q  <= PRW'(wy1_q) * PRW'(dy1_q);
      pcx2_q  <= PRW'(wx1_q) * PRW'(dy1_q);
      pcy2_q  <= PRW'(wy1_q) * PRW'(dx1_q);
      swx2_q  <= SQW'(wx1_q) * SQW'(wx1_q);
      swy2_q  <= SQW'(wy1_q) * SQW'(wy1_q);
      sex2_q  <= SQW'(ex1_q) * SQW'(ex1_q);
      sey2_q  <= SQW'(ey1_q) * SQW'(ey1_q);
      scx2_q  <= SQW'(cx1_q) * SQW'(cx1_q);
      scy2_q  <= SQW'(cy1_q) * SQW'(cy1_q);
      sdx2_q  <= LW'(dx1_q) * LW'(dx1_q);
      sdy2_q  <= LW'(dy1_q) * LW'(dy1_q);
      sw2_2_q <= SWW'(stroke_width_q) * SWW'(stroke_width_q);
      bsr2_q  <= 14'(paint_q[7:3])     * 14'(alpha);
      bsg2_q  <= 14'(paint_q[15:10])   * 14'(alpha);
      bsb2_q  <= 14'(paint_q[23:19])   * 14'(alpha);
      bdr2_q  <= 14'(m1_q.dst[15:11])  * 14'(alpha_inv);
      bdg2_q  <= 14'(m1_q.dst[10:5])   * 14'(alpha_inv);
      bdb2_q  <= 14'(m1_q.dst[4:0])    * 14'(alpha_inv);
      m2_q    <= m1_q;
    end
  end

  // stage 3: sums
  logic signed [PRW:0] dot3_q, crs3_q;
  logic [SQW-1:0]      ds3_q, de3_q, dc3_q;
  logic [LW-1:0]       len3_q;
  logic [SWW-1:0]      sw2_3_q;
  logic [13:0]         nr3_q, ng3_q, nb3_q;
  lsp_meta_t           m3_q;

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      dot3_q  <= (PRW+1)'(pdx2_q) + (PRW+1)'(pdy2_q);
      crs3_q  <= (PRW+1)'(pcx2_q) - (PRW+1)'(pcy2_q);
      ds3_q   <= $unsigned(swx2_q) + $unsigned(swy2_q);
      de3_q   <= $unsigned(sex2_q) + $unsigned(sey2_q);
      dc3_q   <= $unsigned(scx2_q) + $unsigned(scy2_q);
      len3_q  <= $unsigned(sdx2_q) + $unsigned(sdy2_q);
      sw2_3_q <= sw2_2_q;
      nr3_q   <= bsr2_q + bdr2_q;
      ng3_q   <= bsg2_q + bdg2_q;
      nb3_q   <= bsb2_q + bdb2_q;
      m3_q    <= m2_q;
    end
  end

  // stage 4: region select, endpoint and circle tests, divide by 255
  logic [CRW-1:0]     cra4_d, cra4_q;
  logic [SWW+LH-1:0]  rlo4_q;
  logic [RLW-LH-1:0]  rhi4_q;
  logic               use_cross4_d, near_ok4_d, use_cross4_q, near_ok4_q;
  logic               sel_start, sel_end, start_ok, end_ok, circ_ok;
  logic [14:0]        tr, tg, tb, ur, ug, ub;
  logic [PixW-1:0]    blend4_d, blend4_q;
  lsp_meta_t          m4_d, m4_q;
  logic [CRW-1:0]     crs3_u;

  assign crs3_u = $unsigned(crs3_q);

  always_comb begin
    cra4_d    = crs3_q[PRW] ? (~crs3_u + CRW'(1)) : crs3_u;
    sel_start = (len3_q <= LW'(SHORT_LIM)) || dot3_q[PRW] || (dot3_q == '0);
    sel_end   = ~sel_start && (MXW'(dot3_q) >= $signed(MXW'(len3_q)));
    start_ok  = (DTW'(ds3_q) << 10) <= (DTW'(sw2_3_q) << SH);
    end_ok    = (DTW'(de3_q) << 10) <= (DTW'(sw2_3_q) << SH);
    circ_ok   = ~clip_enables_q[1] || ((CTW'(dc3_q) << 8) <= (CTW'(clip_radius_sq_q) << SH));
    use_cross4_d = ~sel_start & ~sel_end;
    near_ok4_d   = sel_start ? start_ok : end_ok;
    m4_d      = m3_q;
    m4_d.ok   = m3_q.ok & circ_ok;
    tr = 15'(nr3_q) + 15'd1;
    tg = 15'(ng3_q) + 15'd1;
    tb = 15'(nb3_q) + 15'd1;
    ur = tr + (tr >> 8);
    ug = tg + (tg >> 8);
    ub = tb + (tb >> 8);
    blend4_d = {ur[12:8], ug[13:8], ub[12:8]};
  end

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      cra4_q       <= cra4_d;
      rlo4_q       <= (SWW+LH)'(sw2_3_q) * (SWW+LH)'(len3_q[LH-1:0]);
      rhi4_q       <= (RLW-LH)'(sw2_3_q) * (RLW-LH)'(len3_q[LW-1:LH]);
      use_cross4_q <= use_cross4_d;
      near_ok4_q   <= near_ok4_d;
      blend4_q     <= blend4_d;
      m4_q         <= m4_d;
    end
  end

  // stage 5: partial squares of the cross product, radius times length
  logic [2*H-1:0]    ll5_q;
  logic [H+HI-1:0]   lh5_q;
  logic [2*HI-1:0]   hh5_q;
  logic [RLW-1:0]    rl5_q;
  logic              use_cross5_q, near_ok5_q;
  logic [PixW-1:0]   blend5_q;
  lsp_meta_t         m5_q;

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      ll5_q        <= (2*H)'(cra4_q[H-1:0]) * (2*H)'(cra4_q[H-1:0]);
      lh5_q        <= (H+HI)'(cra4_q[H-1:0]) * (H+HI)'(cra4_q[CRW-1:H]);
      hh5_q        <= (2*HI)'(cra4_q[CRW-1:H]) * (2*HI)'(cra4_q[CRW-1:H]);
      rl5_q        <= RLW'(rlo4_q) + (RLW'(rhi4_q) << LH);
      use_cross5_q <= use_cross4_q;
      near_ok5_q   <= near_ok4_q;
      blend5_q     <= blend4_q;
      m5_q         <= m4_q;
    end
  end

  // stage 6: assemble the squared cross product
  logic [CQW-1:0]    cq6_q;
  logic [RLW-1:0]    rl6_q;
  logic              use_cross6_q, near_ok6_q;
  logic [PixW-1:0]   blend6_q;
  lsp_meta_t         m6_q;

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      cq6_q        <= CQW'(ll5_q) + (CQW'(lh5_q) << (H + 1)) + (CQW'(hh5_q) << (2 * H));
      rl6_q        <= rl5_q;
      use_cross6_q <= use_cross5_q;
      near_ok6_q   <= near_ok5_q;
      blend6_q     <= blend5_q;
      m6_q         <= m5_q;
    end
  end

  // stage 7: band test, final select, output register
  logic              cross_ok, hit7_d, hit7_q;
  logic [PixW-1:0]   pix7_d, pix7_q, src565;
  logic [CoordW-1:0] x7_q, y7_q;

  always_comb begin
    cross_ok = (CMPW'(cq6_q) << 10) <= (CMPW'(rl6_q) << SH);
    hit7_d   = m6_q.ok & (use_cross6_q ? cross_ok : near_ok6_q);
    src565   = {paint_q[7:3], paint_q[15:10], paint_q[23:19]};
    if (!hit7_d) begin
      pix7_d = m6_q.dst;
    end else if (alpha >= 8'd250) begin
      pix7_d = src565;
    end else begin
      pix7_d = blend6_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[7]) begin
      hit7_q <= hit7_d;
      pix7_q <= pix7_d;
      x7_q   <= m6_q.x;
      y7_q   <= m6_q.y;
    end
  end

  assign out_if.valid     = v_q[7];
  assign out_if.out_x     = x7_q;
  assign out_if.out_y     = y7_q;
  assign out_if.new_pixel = pix7_q;
  assign out_if.covered   = hit7_q;

  // checks
  a_backpressure_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_if.ready |-> (out_if.valid && !out_if.ready && (&v_q)))
    else $error("input stalled while pipeline has room");

  a_zero_alpha : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && paint_q[31:24] == 8'd0) |-> !out_if.covered)
    else $error("covered with zero alpha");

  a_thin_line : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && stroke_width_q <= 12'd8) |-> !out_if.covered)
    else $error("covered with thin stroke");

  a_box_clip : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && clip_enables_q[0] && out_if.out_x < clip_box_q[9:0]) |->
      !out_if.covered)
    else $error("covered left of clip box");

endmodule
